// ===== hdl/encoder_position_pid_drive_top_macros.svh =====
// Assertion macros for the encoder position PID drive checker.
`ifndef ENCODER_POSITION_PID_DRIVE_TOP_MACROS_SVH
`define ENCODER_POSITION_PID_DRIVE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/epd_pkg.sv =====
package epd_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int MUL_W     = 33;
    localparam int PROD_W    = 64;
    localparam int DIVD_W    = 64;
    localparam int DIVS_W    = 16;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd1;
    localparam logic [1:0] ACT_RESET = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CPR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd5;

    localparam int unsigned DUTY_SCALE_DEF = 500;
    localparam logic [16:0] DEG_SCALE      = 17'd92160;
    localparam logic [10:0] TS_Q16         = 11'd1966;
    localparam logic [17:0] DIV3_RECIP     = 18'd174763;
    localparam logic [1:0]  DIV3_LAST      = 2'd3;
    localparam logic [8:0]  DUTY_MAX       = 9'd511;
    localparam logic signed [31:0] DRIVE_ONE = 32'sd65536;
    localparam logic [62:0] TERM_LIMIT     = 63'h1000_0000_0000_0000;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] encoder_delta;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] position_deg;
        logic signed [31:0] control_value;
        logic [8:0]         forward_duty;
        logic [8:0]         reverse_duty;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAG,
        S_DEG_MUL,
        S_DEG_DIV,
        S_DEG_WAIT,
        S_ERR,
        S_TS_MUL,
        S_INTEG,
        S_P_TERM,
        S_D_TERM,
        S_I_HI,
        S_I_LO,
        S_D_WAIT,
        S_SUM_PI,
        S_SUM_D,
        S_CTRL,
        S_DUTY,
        S_DUTY_MUL,
        S_DUTY_SAT,
        S_OUT
    } t_state;

endpackage

// ===== hdl/encoder_position_pid_drive_top.sv =====
// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_ready  i_in_data  (epd_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready o_out_data (epd_pkg::t_out_item)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Stop and reset go straight to the duty stage; a tick or an unknown action first converts
// the position to degrees, and only a tick with the loop enabled runs the PID terms.
// The degree conversion uses the divider, one quotient bit per cycle over a 64-bit
// dividend; the D term divides by three in four 16-bit steps.
// Reset is synchronous and active low; it clears the state, configuration, position and PID memory.
// A new item is taken while a result still waits in the output register; the sequencer
// holds its finished result until that register is free.
module encoder_position_pid_drive_top #(
    parameter int unsigned DUTY_SCALE = epd_pkg::DUTY_SCALE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  epd_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output epd_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [epd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [31:0]                       i_cfg_data
);

    epd_pkg::t_state r_state;
    epd_pkg::t_state n_state;

    logic signed [31:0] r_gain_p;
    logic signed [31:0] r_gain_i;
    logic signed [31:0] r_gain_d;
    logic signed [31:0] r_target;
    logic [15:0]        r_cpr;
    logic               r_enable;

    logic [31:0]        r_pos;
    logic signed [47:0] r_integ;
    logic signed [31:0] r_prev;

    logic               r_run_pid;
    logic [31:0]        r_cmag;
    logic               r_cneg;
    logic signed [31:0] r_deg;
    logic signed [31:0] r_ek;
    logic signed [32:0] r_diff;
    logic [31:0]        r_kmag;
    logic [47:0]        r_imag;
    logic               r_ineg;
    logic signed [62:0] r_p;
    logic [55:0]        r_iacc;
    logic [63:0]        r_dmag;
    logic               r_dneg;
    logic [63:0]        r_dq;
    logic [1:0]         r_dr;
    logic [1:0]         r_dstep;
    logic [60:0]        r_dval;
    logic signed [62:0] r_sum;
    logic signed [31:0] r_ctrl;
    logic [16:0]        r_drv_mag;
    logic               r_drv_pos;
    logic               r_drv_neg;
    logic [8:0]         r_fwd;
    logic [8:0]         r_rev;

    logic               r_out_valid;
    epd_pkg::t_out_item r_out_data;

    logic in_fire;
    logic out_load;

    logic signed [epd_pkg::MUL_W-1:0]  mul_a;
    logic signed [epd_pkg::MUL_W-1:0]  mul_b;
    logic signed [epd_pkg::PROD_W-1:0] mul_prod;

    logic                        div_start;
    logic [epd_pkg::DIVD_W-1:0]  div_dividend;
    logic [epd_pkg::DIVS_W-1:0]  div_divisor;
    epd_pkg::t_div_stat          div_stat;
    logic [epd_pkg::DIVD_W-1:0]  div_quo;

    logic [15:0]        cpr_eff;
    logic [31:0]        pos_tick;
    logic               deg_over;
    logic signed [31:0] deg_val;
    logic signed [32:0] err_full;
    logic signed [31:0] err_sat;
    logic signed [48:0] integ_sum;
    logic signed [47:0] integ_sat;
    logic signed [63:0] p_bias;
    logic signed [63:0] p_shift;
    logic [67:0]        d_x25;
    logic [17:0]        d3_num;
    logic [35:0]        d3_prod;
    logic [15:0]        d3_quo;
    logic [1:0]         d3_rem;
    logic [63:0]        d3_last;
    logic [62:0]        i_ext;
    logic [62:0]        i_signed;
    logic [62:0]        d_ext;
    logic [62:0]        d_signed;
    logic               sum_fits;
    logic [47:0]        duty_raw;
    logic [8:0]         duty_sat;

    assign in_fire    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == epd_pkg::S_OUT) && (!r_out_valid || i_out_ready);
    assign o_in_ready = (r_state == epd_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
            r_target <= '0;
            r_cpr    <= 16'd1;
            r_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                epd_pkg::CFG_GAIN_P: r_gain_p <= i_cfg_data;
                epd_pkg::CFG_GAIN_I: r_gain_i <= i_cfg_data;
                epd_pkg::CFG_GAIN_D: r_gain_d <= i_cfg_data;
                epd_pkg::CFG_TARGET: r_target <= i_cfg_data;
                epd_pkg::CFG_CPR:    r_cpr    <= i_cfg_data[15:0];
                epd_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    epd_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    epd_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_stat      (div_stat),
        .o_quotient  (div_quo)
    );

    assign cpr_eff  = (r_cpr == 16'd0) ? 16'd1 : r_cpr;
    assign pos_tick = r_pos + {{16{i_in_data.encoder_delta[15]}}, i_in_data.encoder_delta};

    assign deg_over = |div_quo[63:31];
    always_comb begin
        if (r_cneg) begin
            deg_val = deg_over ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
        end else begin
            deg_val = deg_over ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
        end
    end

    assign err_full = $signed({r_target[31], r_target}) - $signed({r_deg[31], r_deg});
    always_comb begin
        if (err_full[32] != err_full[31]) begin
            err_sat = err_full[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            err_sat = err_full[31:0];
        end
    end

    assign integ_sum = $signed({r_integ[47], r_integ}) + $signed(mul_prod[48:0]);
    always_comb begin
        if (integ_sum[48] != integ_sum[47]) begin
            integ_sat = {integ_sum[48], {47{~integ_sum[48]}}};
        end else begin
            integ_sat = integ_sum[47:0];
        end
    end

    assign p_bias  = mul_prod + $signed({56'd0, {8{mul_prod[63]}}});
    assign p_shift = p_bias >>> 8;

    // The D term is floor(25 * m / 192): scale by 25, drop six bits, then divide by three
    // one 16-bit digit per step, from the top.
    assign d_x25   = {r_dmag, 4'd0} + {1'b0, r_dmag, 3'd0} + {4'd0, r_dmag};
    assign d3_num  = {r_dr, r_dq[63:48]};
    assign d3_prod = d3_num * epd_pkg::DIV3_RECIP;
    assign d3_quo  = d3_prod[34:19];
    assign d3_rem  = d3_num[1:0] - ({d3_quo[0], 1'b0} + d3_quo[1:0]);
    assign d3_last = {r_dq[47:0], d3_quo};

    assign i_ext    = {7'd0, r_iacc};
    assign i_signed = r_ineg ? (~i_ext + 63'd1) : i_ext;
    assign d_ext    = {2'd0, r_dval};
    assign d_signed = r_dneg ? (~d_ext + 63'd1) : d_ext;
    assign sum_fits = (r_sum[62:31] == {32{r_sum[31]}});

    assign duty_raw = mul_prod[63:16];
    assign duty_sat = (|duty_raw[47:9]) ? epd_pkg::DUTY_MAX : duty_raw[8:0];

    always_comb begin
        n_state      = r_state;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = mul_prod;
        div_divisor  = cpr_eff;
        case (r_state)
            epd_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.action == epd_pkg::ACT_STOP ||
                        i_in_data.action == epd_pkg::ACT_RESET) begin
                        n_state = epd_pkg::S_DUTY;
                    end else begin
                        n_state = epd_pkg::S_MAG;
                    end
                end
            end
            epd_pkg::S_MAG:     n_state = epd_pkg::S_DEG_MUL;
            epd_pkg::S_DEG_MUL: begin
                mul_a   = $signed({1'b0, r_cmag});
                mul_b   = $signed({16'd0, epd_pkg::DEG_SCALE});
                n_state = epd_pkg::S_DEG_DIV;
            end
            epd_pkg::S_DEG_DIV: begin
                div_start    = !div_stat.busy;
                n_state      = div_stat.busy ? epd_pkg::S_DEG_DIV : epd_pkg::S_DEG_WAIT;
            end
            epd_pkg::S_DEG_WAIT: begin
                if (div_stat.done) begin
                    n_state = r_run_pid ? epd_pkg::S_ERR : epd_pkg::S_DUTY;
                end
            end
            epd_pkg::S_ERR:     n_state = epd_pkg::S_TS_MUL;
            epd_pkg::S_TS_MUL: begin
                mul_a   = $signed({r_ek[31], r_ek});
                mul_b   = $signed({22'd0, epd_pkg::TS_Q16});
                n_state = epd_pkg::S_INTEG;
            end
            epd_pkg::S_INTEG: begin
                mul_a   = $signed({r_gain_p[31], r_gain_p});
                mul_b   = $signed({r_ek[31], r_ek});
                n_state = epd_pkg::S_P_TERM;
            end
            epd_pkg::S_P_TERM: begin
                mul_a   = $signed({r_gain_d[31], r_gain_d});
                mul_b   = r_diff;
                n_state = epd_pkg::S_D_TERM;
            end
            epd_pkg::S_D_TERM: begin
                mul_a   = $signed({1'b0, r_kmag});
                mul_b   = $signed({9'd0, r_imag[47:24]});
                n_state = epd_pkg::S_I_HI;
            end
            epd_pkg::S_I_HI: begin
                mul_a   = $signed({1'b0, r_kmag});
                mul_b   = $signed({9'd0, r_imag[23:0]});
                n_state = epd_pkg::S_I_LO;
            end
            epd_pkg::S_I_LO: begin
                n_state   = epd_pkg::S_D_WAIT;
            end
            epd_pkg::S_D_WAIT: begin
                if (r_dstep == epd_pkg::DIV3_LAST) begin
                    n_state = epd_pkg::S_SUM_PI;
                end
            end
            epd_pkg::S_SUM_PI:  n_state = epd_pkg::S_SUM_D;
            epd_pkg::S_SUM_D:   n_state = epd_pkg::S_CTRL;
            epd_pkg::S_CTRL:    n_state = epd_pkg::S_DUTY;
            epd_pkg::S_DUTY:    n_state = epd_pkg::S_DUTY_MUL;
            epd_pkg::S_DUTY_MUL: begin
                mul_a   = $signed({16'd0, r_drv_mag});
                mul_b   = $signed(epd_pkg::MUL_W'(DUTY_SCALE));
                n_state = epd_pkg::S_DUTY_SAT;
            end
            epd_pkg::S_DUTY_SAT: n_state = epd_pkg::S_OUT;
            epd_pkg::S_OUT: begin
                if (out_load) begin
                    n_state = epd_pkg::S_IDLE;
                end
            end
            default: n_state = epd_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_integ <= '0;
            r_prev  <= '0;
        end else begin
            case (r_state)
                epd_pkg::S_IDLE: begin
                    if (in_fire) begin
                        case (i_in_data.action)
                            epd_pkg::ACT_TICK: r_pos <= pos_tick;
                            epd_pkg::ACT_STOP: r_pos <= '0;
                            epd_pkg::ACT_RESET: begin
                                r_pos   <= '0;
                                r_integ <= '0;
                                r_prev  <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                epd_pkg::S_INTEG: begin
                    r_integ <= integ_sat;
                    r_prev  <= r_ek;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            epd_pkg::S_IDLE: begin
                r_run_pid <= (i_in_data.action == epd_pkg::ACT_TICK) && r_enable;
                r_deg     <= '0;
                r_ctrl    <= '0;
            end
            epd_pkg::S_MAG: begin
                r_cmag <= r_pos[31] ? (~r_pos + 32'd1) : r_pos;
                r_cneg <= r_pos[31];
            end
            epd_pkg::S_DEG_WAIT: begin
                if (div_stat.done) begin
                    r_deg <= deg_val;
                end
            end
            epd_pkg::S_ERR: r_ek <= err_sat;
            epd_pkg::S_TS_MUL: begin
                r_diff <= $signed({r_ek[31], r_ek}) - $signed({r_prev[31], r_prev});
                r_kmag <= r_gain_i[31] ? (~r_gain_i + 32'd1) : r_gain_i;
            end
            epd_pkg::S_P_TERM: begin
                r_p    <= p_shift[62:0];
                r_imag <= r_integ[47] ? (~r_integ + 48'd1) : r_integ;
                r_ineg <= r_gain_i[31] != r_integ[47];
            end
            epd_pkg::S_D_TERM: begin
                r_dmag <= mul_prod[63] ? (~mul_prod + 64'd1) : mul_prod;
                r_dneg <= mul_prod[63];
            end
            epd_pkg::S_I_HI: r_iacc <= mul_prod[55:0];
            epd_pkg::S_I_LO: begin
                r_iacc  <= r_iacc + {24'd0, mul_prod[55:24]};
                r_dq    <= {2'd0, d_x25[67:6]};
                r_dr    <= '0;
                r_dstep <= '0;
            end
            epd_pkg::S_D_WAIT: begin
                r_dq    <= d3_last;
                r_dr    <= d3_rem;
                r_dstep <= r_dstep + 2'd1;
                if (r_dstep == epd_pkg::DIV3_LAST) begin
                    r_dval <= (d3_last > {1'b0, epd_pkg::TERM_LIMIT}) ?
                              epd_pkg::TERM_LIMIT[60:0] : d3_last[60:0];
                end
            end
            epd_pkg::S_SUM_PI: r_sum <= r_p + $signed(i_signed);
            epd_pkg::S_SUM_D:  r_sum <= r_sum + $signed(d_signed);
            epd_pkg::S_CTRL: begin
                if (sum_fits) begin
                    r_ctrl <= r_sum[31:0];
                end else begin
                    r_ctrl <= r_sum[62] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                end
            end
            epd_pkg::S_DUTY: begin
                r_drv_pos <= r_ctrl > 32'sd0;
                r_drv_neg <= r_ctrl[31];
                if (r_ctrl > epd_pkg::DRIVE_ONE || r_ctrl < -epd_pkg::DRIVE_ONE) begin
                    r_drv_mag <= 17'h1_0000;
                end else if (r_ctrl[31]) begin
                    r_drv_mag <= 17'(-r_ctrl);
                end else begin
                    r_drv_mag <= r_ctrl[16:0];
                end
            end
            epd_pkg::S_DUTY_SAT: begin
                r_fwd <= r_drv_pos ? duty_sat : 9'd0;
                r_rev <= r_drv_neg ? duty_sat : 9'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.position_deg  <= r_deg;
            r_out_data.control_value <= r_ctrl;
            r_out_data.forward_duty  <= r_fwd;
            r_out_data.reverse_duty  <= r_rev;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== hdl/epd_mul.sv =====
module epd_mul (
    input  logic                                i_clk,
    input  logic signed [epd_pkg::MUL_W-1:0]    i_a,
    input  logic signed [epd_pkg::MUL_W-1:0]    i_b,
    output logic signed [epd_pkg::PROD_W-1:0]   o_prod
);

    logic signed [2*epd_pkg::MUL_W-1:0] n_prod;
    logic signed [epd_pkg::PROD_W-1:0]  r_prod;

    assign n_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod[epd_pkg::PROD_W-1:0];
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/epd_div.sv =====
module epd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [epd_pkg::DIVD_W-1:0]         i_dividend,
    input  logic [epd_pkg::DIVS_W-1:0]         i_divisor,
    output epd_pkg::t_div_stat                 o_stat,
    output logic [epd_pkg::DIVD_W-1:0]         o_quotient
);

    localparam int CNT_W = $clog2(epd_pkg::DIVD_W);

    logic [epd_pkg::DIVD_W-1:0] r_quo;
    logic [epd_pkg::DIVS_W-1:0] r_rem;
    logic [epd_pkg::DIVS_W-1:0] r_dvs;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [epd_pkg::DIVS_W:0]   rem_sh;
    logic [epd_pkg::DIVS_W:0]   rem_sub;
    logic                       rem_ge;

    assign rem_sh  = {r_rem, r_quo[epd_pkg::DIVD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(epd_pkg::DIVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[epd_pkg::DIVD_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[epd_pkg::DIVS_W-1:0] : rem_sh[epd_pkg::DIVS_W-1:0];
        end
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;

endmodule

// ===== hdl/epd_chk.sv =====
`include "encoder_position_pid_drive_top_macros.svh"

module epd_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input epd_pkg::t_out_item i_out_data
);

    // Only one drive channel may be active at a time.
    `EPD_ASSERT_NOW(a_one_channel, i_out_valid, (i_out_data.forward_duty == 9'd0) || (i_out_data.reverse_duty == 9'd0), "both drive channels are active")

    // Forward drive requires a positive control value.
    `EPD_ASSERT_NOW(a_fwd_sign, i_out_valid && (i_out_data.forward_duty != 9'd0), i_out_data.control_value > 32'sd0, "forward duty without positive control")

    // Reverse drive requires a negative control value.
    `EPD_ASSERT_NOW(a_rev_sign, i_out_valid && (i_out_data.reverse_duty != 9'd0), i_out_data.control_value < 32'sd0, "reverse duty without negative control")

    // The block works on one item at a time after an input transfer.
    `EPD_ASSERT_NEXT(a_busy_after_take, i_in_valid && i_in_ready, !i_in_ready, "input ready right after a transfer")

    // A stalled result stays valid and unchanged.
    `EPD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")

endmodule

bind encoder_position_pid_drive_top epd_chk u_epd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
